### rtl/nfsa_pkg.sv
`timescale 1ns / 1ps

package nfsa_pkg;

    // Port field widths
    localparam int OPCODE_W      = 2;
    localparam int INDEX_W       = 9;
    localparam int HANDLE_PORT_W = 32;
    localparam int STATUS_W      = 2;

    // Occupancy scan window: bits examined per cycle
    localparam int SCAN_W     = 16;
    localparam int SCAN_OFS_W = 4;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam opcode_t OP_ALLOC  = 2'd0;
    localparam opcode_t OP_FREE   = 2'd1;
    localparam opcode_t OP_LOOKUP = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;
    localparam status_t ST_EMPTY = 2'd3;

endpackage

### rtl/nfsa_store.sv
`timescale 1ns / 1ps

module nfsa_store
    import nfsa_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/nfsa_scan.sv
`timescale 1ns / 1ps

module nfsa_scan
    import nfsa_pkg::*;
#(
    parameter int TABLE_SIZE = 256,
    parameter int WORD_W     = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [WORD_W+SCAN_OFS_W-1:0] start_slot,
    input  logic [SCAN_W-1:0]            occ_word,
    output logic [WORD_W-1:0]            word_idx,
    output logic                         done,
    output logic [WORD_W+SCAN_OFS_W-1:0] found_slot
);

    localparam int NUM_WORDS = (TABLE_SIZE + SCAN_W - 1) / SCAN_W;
    localparam int TAIL      = TABLE_SIZE % SCAN_W;
    localparam logic [SCAN_W-1:0] LAST_MASK =
        (TAIL == 0) ? {SCAN_W{1'b1}} : SCAN_W'((1 << TAIL) - 1);

    logic                  busy_reg, busy_next;
    logic                  first_reg, first_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [SCAN_OFS_W-1:0] ofs_reg, ofs_next;
    logic [SCAN_W-1:0]     cand;
    logic [SCAN_W-1:0]     pad_mask;
    logic [SCAN_W-1:0]     ofs_mask;
    logic [SCAN_OFS_W-1:0] pick;

    // padding slots past the end of the table count as taken
    assign pad_mask = (word_reg == WORD_W'(NUM_WORDS - 1)) ? LAST_MASK : {SCAN_W{1'b1}};
    // on the first visit skip slots below the search pointer
    assign ofs_mask = first_reg ? ({SCAN_W{1'b1}} << ofs_reg) : {SCAN_W{1'b1}};
    assign cand     = ~occ_word & pad_mask & ofs_mask;

    always_comb
    begin
        pick = '0;
        for (int i = SCAN_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pick = SCAN_OFS_W'(i);
            end
        end
    end

    assign done       = busy_reg && (cand != '0);
    assign found_slot = {word_reg, pick};
    assign word_idx   = word_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        first_next = first_reg;
        word_next  = word_reg;
        ofs_next   = ofs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            word_next  = start_slot[WORD_W+SCAN_OFS_W-1:SCAN_OFS_W];
            ofs_next   = start_slot[SCAN_OFS_W-1:0];
        end
        else if (busy_reg)
        begin
            if (cand != '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                // advance to the next word, wrap at the end of the table
                first_next = 1'b0;
                word_next  = (word_reg == WORD_W'(NUM_WORDS - 1)) ? '0 : word_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            word_reg  <= '0;
            ofs_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            first_reg <= first_next;
            word_reg  <= word_next;
            ofs_reg   <= ofs_next;
        end
    end

endmodule

### rtl/next_fit_slot_allocator.sv
`timescale 1ns / 1ps

// Next-fit slot allocator over TABLE_SIZE slots. One transaction is taken at a
// time: free, lookup, unused opcodes and allocate on a full table load their
// result straight from the idle state; lookup of a held slot first reads the
// handle memory, which has a registered read port; any other allocate runs a
// single 16-bit occupancy window scanner that walks the table one word a cycle
// from the search pointer and may revisit the starting word after wrapping.
// The input stalls while a transaction is in work or its result waits to be
// taken, so the next transaction is accepted no earlier than the cycle after
// the result is taken.

module next_fit_slot_allocator
    import nfsa_pkg::*;
#(
    parameter int TABLE_SIZE   = 256,
    parameter int HANDLE_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OPCODE_W-1:0]      opcode,
    input  logic [INDEX_W-1:0]       slot_index,
    input  logic [HANDLE_PORT_W-1:0] entry_handle,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [INDEX_W-1:0]       granted_index,
    output logic [HANDLE_PORT_W-1:0] stored_handle,
    output logic [STATUS_W-1:0]      status,
    output logic [INDEX_W-1:0]       free_slots
);

    localparam int NUM_WORDS = (TABLE_SIZE + SCAN_W - 1) / SCAN_W;
    localparam int WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SLOT_W    = WORD_W + SCAN_OFS_W;
    localparam int STORE_AW  = $clog2(TABLE_SIZE);
    localparam int CNT_W     = $clog2(TABLE_SIZE + 1);
    localparam int STORE_DW  = (HANDLE_WIDTH < HANDLE_PORT_W) ? HANDLE_WIDTH : HANDLE_PORT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         free_reg, free_next;
    logic [CNT_W-1:0]         search_reg, search_next;
    logic [STORE_DW-1:0]      handle_reg, handle_next;
    logic [SCAN_W-1:0]        occ_reg [NUM_WORDS];

    logic                     out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]       granted_reg, granted_next;
    logic [HANDLE_PORT_W-1:0] rd_handle_reg, rd_handle_next;
    status_t                  status_reg, status_next;
    logic [INDEX_W-1:0]       free_out_reg, free_out_next;

    logic                     accept;
    logic                     in_range;
    logic [SLOT_W-1:0]        idx_sel;
    logic                     idx_held;
    logic [SLOT_W-1:0]        start_slot;
    logic                     load;
    logic                     scan_start;
    logic                     occ_set;
    logic                     occ_clr;
    logic                     rd_en;
    logic                     wr_en;

    logic [WORD_W-1:0]        scan_word;
    logic                     scan_done;
    logic [SLOT_W-1:0]        scan_slot;
    logic [STORE_DW-1:0]      rd_data;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;

    assign in_range = (slot_index != '0) && (32'(slot_index) <= 32'(TABLE_SIZE));
    assign idx_sel  = SLOT_W'(slot_index - INDEX_W'(1));
    assign idx_held = occ_reg[idx_sel[SLOT_W-1:SCAN_OFS_W]][idx_sel[SCAN_OFS_W-1:0]];

    // a pointer one past the last slot wraps to the first
    assign start_slot = (search_reg == CNT_W'(TABLE_SIZE)) ? '0 : SLOT_W'(search_reg);

    nfsa_scan #(
        .TABLE_SIZE (TABLE_SIZE),
        .WORD_W     (WORD_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .start_slot (start_slot),
        .occ_word   (occ_reg[scan_word]),
        .word_idx   (scan_word),
        .done       (scan_done),
        .found_slot (scan_slot)
    );

    nfsa_store #(
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (STORE_AW),
        .DATA_W (STORE_DW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (STORE_AW'(scan_slot)),
        .wr_data (handle_reg),
        .rd_en   (rd_en),
        .rd_addr (STORE_AW'(idx_sel)),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        free_next      = free_reg;
        search_next    = search_reg;
        handle_next    = handle_reg;
        out_valid_next = out_valid_reg && out_stall;
        granted_next   = granted_reg;
        rd_handle_next = rd_handle_reg;
        status_next    = status_reg;
        free_out_next  = free_out_reg;
        load           = 1'b0;
        scan_start     = 1'b0;
        occ_set        = 1'b0;
        occ_clr        = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    handle_next = entry_handle[STORE_DW-1:0];
                    priority if (opcode == OP_ALLOC)
                    begin
                        if (free_reg == '0)
                        begin
                            load         = 1'b1;
                            granted_next = '0;
                            status_next  = ST_FULL;
                        end
                        else
                        begin
                            scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    else if ((opcode == OP_FREE) || (opcode == OP_LOOKUP))
                    begin
                        priority if (!in_range)
                        begin
                            load         = 1'b1;
                            granted_next = '0;
                            status_next  = ST_RANGE;
                        end
                        else if (!idx_held)
                        begin
                            load         = 1'b1;
                            granted_next = '0;
                            status_next  = ST_EMPTY;
                        end
                        else if (opcode == OP_FREE)
                        begin
                            occ_clr      = 1'b1;
                            free_next    = free_reg + 1'b1;
                            search_next  = CNT_W'(idx_sel);
                            load         = 1'b1;
                            granted_next = '0;
                            status_next  = ST_OK;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        load         = 1'b1;
                        granted_next = '0;
                        status_next  = ST_OK;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    occ_set      = 1'b1;
                    wr_en        = 1'b1;
                    free_next    = free_reg - 1'b1;
                    search_next  = CNT_W'(scan_slot) + CNT_W'(1);
                    load         = 1'b1;
                    granted_next = INDEX_W'(scan_slot) + INDEX_W'(1);
                    status_next  = ST_OK;
                    state_next   = S_IDLE;
                end
            end
            S_READ:
            begin
                load           = 1'b1;
                granted_next   = '0;
                status_next    = ST_OK;
                rd_handle_next = HANDLE_PORT_W'(rd_data);
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
            free_out_next  = INDEX_W'(free_next);
            if (state_reg != S_READ)
            begin
                rd_handle_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= CNT_W'(TABLE_SIZE);
            search_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                occ_reg[w] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            search_reg    <= search_next;
            out_valid_reg <= out_valid_next;
            if (occ_set)
            begin
                occ_reg[scan_slot[SLOT_W-1:SCAN_OFS_W]][scan_slot[SCAN_OFS_W-1:0]] <= 1'b1;
            end
            if (occ_clr)
            begin
                occ_reg[idx_sel[SLOT_W-1:SCAN_OFS_W]][idx_sel[SCAN_OFS_W-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg    <= handle_next;
        granted_reg   <= granted_next;
        rd_handle_reg <= rd_handle_next;
        status_reg    <= status_next;
        free_out_reg  <= free_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign granted_index = granted_reg;
    assign stored_handle = rd_handle_reg;
    assign status        = status_reg;
    assign free_slots    = free_out_reg;

endmodule

### rtl/nfsa_checker.sv
`timescale 1ns / 1ps

module nfsa_checker
    import nfsa_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [INDEX_W-1:0]       granted_index,
    input logic [HANDLE_PORT_W-1:0] stored_handle,
    input logic [STATUS_W-1:0]      status,
    input logic [INDEX_W-1:0]       free_slots
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(granted_index)
            && $stable(stored_handle) && $stable(status) && $stable(free_slots))
        else $error("stalled result changed");

    // no new transaction while a result is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while result pending");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (granted_index != '0) |-> (status == ST_OK) && (stored_handle == '0))
        else $error("grant with bad status or handle");

    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (stored_handle != '0) |-> (status == ST_OK))
        else $error("handle returned on failed lookup");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (free_slots == '0))
        else $error("table full with free slots left");

endmodule

bind next_fit_slot_allocator nfsa_checker u_nfsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .granted_index (granted_index),
    .stored_handle (stored_handle),
    .status        (status),
    .free_slots    (free_slots)
);

### tb/sv/next_fit_slot_allocator_tb.sv
`timescale 1ns / 1ps

module next_fit_slot_allocator_tb;
    import nfsa_pkg::*;

    localparam int SLOTS       = 256;
    localparam int RAND_ITEMS  = 1250;
    localparam int QUIET_ITEMS = 200;
    localparam int SEG_LEN     = 50;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 400;

    localparam opcode_t OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [INDEX_W-1:0]       granted;
        logic [HANDLE_PORT_W-1:0] handle;
        status_t                  st;
        logic [INDEX_W-1:0]       free_left;
    } slot_result_t;

    typedef struct packed {
        opcode_t                  op;
        logic [INDEX_W-1:0]       idx;
        logic [HANDLE_PORT_W-1:0] handle;
        bit                       typed;
        slot_result_t             res;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [OPCODE_W-1:0]      opcode;
    logic [INDEX_W-1:0]       slot_index;
    logic [HANDLE_PORT_W-1:0] entry_handle;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [INDEX_W-1:0]       granted_index;
    logic [HANDLE_PORT_W-1:0] stored_handle;
    logic [STATUS_W-1:0]      status;
    logic [INDEX_W-1:0]       free_slots;

    next_fit_slot_allocator #(
        .TABLE_SIZE   (SLOTS),
        .HANDLE_WIDTH (HANDLE_PORT_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .slot_index    (slot_index),
        .entry_handle  (entry_handle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_index (granted_index),
        .stored_handle (stored_handle),
        .status        (status),
        .free_slots    (free_slots)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the slot table
    bit   [SLOTS-1:0]         slot_busy;
    logic [HANDLE_PORT_W-1:0] slot_handle [0:SLOTS-1];
    logic [INDEX_W-1:0]       model_free;
    logic [INDEX_W-1:0]       model_cursor;

    slot_result_t pending_results [$];
    stim_row_t    directed_rows [$];
    int           errors        = 0;
    int           results_taken = 0;
    int           cycles        = 0;
    bit           idle_on       = 1'b1;
    bit           hold_done     = 1'b0;
    int           hold_left     = 0;
    int           stall_left    = 0;

    task automatic predict_slot_op(input opcode_t op, input logic [INDEX_W-1:0] idx,
                                   input logic [HANDLE_PORT_W-1:0] handle,
                                   output slot_result_t r);
        int pos;
        int n;
        bit found;
        r     = '0;
        r.st  = ST_OK;
        found = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                if (model_free != 0)
                begin
                    pos = model_cursor;
                    n   = 0;
                    while (n < SLOTS && !found)
                    begin
                        if (pos >= SLOTS)
                            pos = 0;
                        if (!slot_busy[pos])
                        begin
                            slot_busy[pos]   = 1'b1;
                            slot_handle[pos] = handle;
                            model_free       = model_free - 1'b1;
                            model_cursor     = INDEX_W'(pos + 1);
                            r.granted        = INDEX_W'(pos + 1);
                            found            = 1'b1;
                        end
                        else
                        begin
                            pos++;
                            n++;
                        end
                    end
                end
                if (!found)
                    r.st = ST_FULL;
            end
            OP_FREE, OP_LOOKUP:
            begin
                if (idx < 1 || idx > SLOTS)
                    r.st = ST_RANGE;
                else if (!slot_busy[idx - 1])
                    r.st = ST_EMPTY;
                else if (op == OP_FREE)
                begin
                    slot_busy[idx - 1] = 1'b0;
                    model_cursor       = idx - 1'b1;
                    model_free         = model_free + 1'b1;
                end
                else
                    r.handle = slot_handle[idx - 1];
            end
            default:
                ;
        endcase
        r.free_left = model_free;
    endtask

    // Pick a held slot, or any slot when the table is empty
    function automatic logic [INDEX_W-1:0] pick_busy_slot();
        int s;
        int n;
        s = $urandom_range(0, SLOTS - 1);
        for (n = 0; n < SLOTS; n++)
        begin
            if (slot_busy[(s + n) % SLOTS])
                return INDEX_W'((s + n) % SLOTS + 1);
        end
        return INDEX_W'(s + 1);
    endfunction

    task automatic issue(input opcode_t op, input logic [INDEX_W-1:0] idx,
                         input logic [HANDLE_PORT_W-1:0] handle,
                         input bit typed, input slot_result_t typed_res);
        slot_result_t r;
        @(negedge clk);
        in_valid     <= 1'b1;
        opcode       <= op;
        slot_index   <= idx;
        entry_handle <= handle;
        do
            @(posedge clk);
        while (in_stall);
        predict_slot_op(op, idx, handle, r);
        pending_results.push_back(typed ? typed_res : r);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge clk);
        end
    endtask

    task automatic add_row(input opcode_t op, input logic [INDEX_W-1:0] idx,
                           input logic [HANDLE_PORT_W-1:0] handle, input bit typed,
                           input logic [INDEX_W-1:0] g, input logic [HANDLE_PORT_W-1:0] h,
                           input status_t st, input logic [INDEX_W-1:0] fr);
        stim_row_t row;
        row.op            = op;
        row.idx           = idx;
        row.handle        = handle;
        row.typed         = typed;
        row.res.granted   = g;
        row.res.handle    = h;
        row.res.st        = st;
        row.res.free_left = fr;
        directed_rows.push_back(row);
    endtask

    // Receiver: random stall bursts plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_taken >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 7) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        slot_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_taken++;
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction pending: granted_index %0d status %0d",
                       granted_index, status);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (granted_index !== e.granted)
                begin
                    $error("granted_index: expected %0d, got %0d", e.granted, granted_index);
                    errors++;
                end
                if (stored_handle !== e.handle)
                begin
                    $error("stored_handle: expected %h, got %h", e.handle, stored_handle);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    errors++;
                end
                if (free_slots !== e.free_left)
                begin
                    $error("free_slots: expected %0d, got %0d", e.free_left, free_slots);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int i;
        int alloc_pct;
        int k;
        opcode_t op;
        logic [INDEX_W-1:0] idx;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_ALLOC;
        slot_index   = '0;
        entry_handle = '0;
        slot_busy    = '0;
        model_free   = INDEX_W'(SLOTS);
        model_cursor = '0;

        // Typed rows follow straight from reset; the rest go through the predictor
        add_row(OP_LOOKUP, 9'd1,   32'h0,          1, 9'd0, 32'h0,          ST_EMPTY, 9'd256);
        add_row(OP_FREE,   9'd0,   32'hFFFF_FFFF,  1, 9'd0, 32'h0,          ST_RANGE, 9'd256);
        add_row(OP_FREE,   9'd257, 32'h0,          1, 9'd0, 32'h0,          ST_RANGE, 9'd256);
        add_row(OP_LOOKUP, 9'd511, 32'h0,          1, 9'd0, 32'h0,          ST_RANGE, 9'd256);
        add_row(OP_LOOKUP, 9'd256, 32'h0,          1, 9'd0, 32'h0,          ST_EMPTY, 9'd256);
        add_row(OP_UNUSED, 9'd511, 32'hFFFF_FFFF,  1, 9'd0, 32'h0,          ST_OK,    9'd256);
        add_row(OP_ALLOC,  9'd511, 32'hFFFF_FFFF,  1, 9'd1, 32'h0,          ST_OK,    9'd255);
        add_row(OP_ALLOC,  9'd0,   32'h0,          1, 9'd2, 32'h0,          ST_OK,    9'd254);
        add_row(OP_LOOKUP, 9'd1,   32'h0,          1, 9'd0, 32'hFFFF_FFFF,  ST_OK,    9'd254);
        add_row(OP_LOOKUP, 9'd2,   32'hFFFF_FFFF,  1, 9'd0, 32'h0,          ST_OK,    9'd254);
        add_row(OP_FREE,   9'd1,   32'h0,          1, 9'd0, 32'h0,          ST_OK,    9'd255);
        add_row(OP_FREE,   9'd1,   32'h0,          1, 9'd0, 32'h0,          ST_EMPTY, 9'd255);
        add_row(OP_LOOKUP, 9'd1,   32'h0,          1, 9'd0, 32'h0,          ST_EMPTY, 9'd255);
        add_row(OP_ALLOC,  9'd256, 32'h5A5A_C3C3,  0, '0, '0, ST_OK, '0);
        add_row(OP_ALLOC,  9'd255, 32'h8000_0001,  0, '0, '0, ST_OK, '0);
        add_row(OP_FREE,   9'd2,   32'h0,          0, '0, '0, ST_OK, '0);
        add_row(OP_ALLOC,  9'd0,   32'h1234_5678,  0, '0, '0, ST_OK, '0);
        add_row(OP_LOOKUP, 9'd3,   32'h0,          0, '0, '0, ST_OK, '0);
        add_row(OP_LOOKUP, 9'd1,   32'h0,          0, '0, '0, ST_OK, '0);
        add_row(OP_FREE,   9'd3,   32'h0,          0, '0, '0, ST_OK, '0);
        add_row(OP_LOOKUP, 9'd257, 32'h0,          0, '0, '0, ST_OK, '0);
        add_row(OP_UNUSED, 9'd0,   32'h0,          0, '0, '0, ST_OK, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < directed_rows.size(); i++)
            issue(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].handle,
                  directed_rows[i].typed, directed_rows[i].res);

        // Fill the table, then run into the full case
        while (model_free != 0)
            issue(OP_ALLOC, INDEX_W'($urandom_range(0, 511)), $urandom, 0, '0);
        issue(OP_ALLOC, 9'd0, 32'hFFFF_FFFF, 0, '0);
        issue(OP_ALLOC, 9'd511, 32'h0, 0, '0);
        issue(OP_LOOKUP, 9'd256, 32'h0, 0, '0);

        // Wrap the cursor past the last slot, then force a long scan
        issue(OP_FREE, 9'd1, 32'h0, 0, '0);
        issue(OP_FREE, 9'd256, 32'h0, 0, '0);
        issue(OP_ALLOC, 9'd0, $urandom, 0, '0);
        issue(OP_ALLOC, 9'd0, $urandom, 0, '0);
        issue(OP_FREE, 9'd200, 32'h0, 0, '0);
        issue(OP_FREE, 9'd100, 32'h0, 0, '0);
        issue(OP_ALLOC, 9'd0, $urandom, 0, '0);
        issue(OP_ALLOC, 9'd0, $urandom, 0, '0);
        issue(OP_LOOKUP, 9'd200, 32'h0, 0, '0);

        alloc_pct = 50;
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % SEG_LEN == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       alloc_pct = 15;
                    1:       alloc_pct = 50;
                    default: alloc_pct = 90;
                endcase
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (i >= RAND_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            k = $urandom_range(0, 99);
            if (k < alloc_pct)
            begin
                op  = OP_ALLOC;
                idx = INDEX_W'($urandom_range(0, 511));
            end
            else if (k >= 95)
            begin
                op  = opcode_t'($urandom_range(0, 3));
                idx = INDEX_W'($urandom_range(0, 511));
            end
            else
            begin
                op  = ($urandom_range(0, 1) != 0) ? OP_FREE : OP_LOOKUP;
                idx = ($urandom_range(0, 3) != 0) ? pick_busy_slot()
                                                  : INDEX_W'($urandom_range(1, SLOTS));
            end
            issue(op, idx, $urandom, 0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
